// ===== src/waveform_pulse_timing_and_charge_macros.svh =====
// Assertion macros for the pulse timing and charge block.
// Included by the top level; no other dependencies.
`ifndef WAVEFORM_PULSE_TIMING_AND_CHARGE_MACROS_SVH
`define WAVEFORM_PULSE_TIMING_AND_CHARGE_MACROS_SVH
`ifndef SYNTHESIS
`define WPTC_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define WPTC_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define WPTC_ASSERT_IMP(lbl, clk, rst, a, b)
`define WPTC_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== src/wptc_pkg.sv =====
// Shared types and constants for the pulse timing and charge block.
// No dependencies.
package wptc_pkg;
   localparam int TIME_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int IDX_W    = 13;
   localparam int CNT_OUT_W = 3;
   localparam int CHARGE_W = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LASER_THR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PMT_THR    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_SEL  = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] LASER_THR_RST = 16'sd4000;
   localparam logic signed [SAMPLE_W-1:0] PMT_THR_RST   = -16'sd60;
   localparam logic [2:0] PULSE_SEL_RST = 3'd1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_START = 2'd1;
   localparam logic [1:0] STATUS_END   = 2'd2;

   typedef enum logic [3:0] {
      BK_IDLE, BK_LEFT_RD, BK_LEFT_CHK, BK_RIGHT_RD, BK_RIGHT_CHK,
      BK_INT_RD, BK_INT_CHK, BK_FLUSH, BK_OUT
   } back_state_type;

   typedef struct packed {
      logic [TIME_W-1:0]          laser_peak_time;
      logic [CNT_OUT_W-1:0]       laser_pulse_count;
      logic                       laser_missing;
      logic [IDX_W-1:0]           pmt_peak_index;
      logic signed [SAMPLE_W-1:0] pmt_peak_value;
      logic [IDX_W-1:0]           pmt_start_index;
      logic [IDX_W-1:0]           pmt_end_index;
      logic signed [CHARGE_W-1:0] charge;
      logic [1:0]                 pmt_status;
   } result_type;
endpackage

// ===== src/wptc_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module wptc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/wptc_queue.sv =====
// Two-entry job queue between the sample front end and the record back end.
// No dependencies.
module wptc_queue #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = entry_ff[rd_ptr_ff];
   assign not_empty = (fill_ff != 2'd0);
endmodule

// ===== src/wptc_front.sv =====
// Front end: stores samples, tracks the pmt minimum and the laser pulses.
// Depends on wptc_pkg; pushes one job word per record.
module wptc_front
   import wptc_pkg::*;
#(
   parameter int RECORD_DEPTH = 8192,
   parameter int MAX_PULSES   = 5,
   localparam int AW  = $clog2(RECORD_DEPTH),
   localparam int CW  = $clog2(RECORD_DEPTH + 1),
   localparam int PCW = $clog2(MAX_PULSES + 1),
   localparam int JW  = CW + AW + SAMPLE_W + PCW + 1 + TIME_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic [TIME_W-1:0]          sample_time,
   input  logic signed [SAMPLE_W-1:0] pmt_sample,
   input  logic signed [SAMPLE_W-1:0] laser_sample,
   input  logic                       last_sample,
   input  logic signed [SAMPLE_W-1:0] laser_thr,
   input  logic [2:0]                 pulse_sel,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic                       job_push,
   output logic [JW-1:0]              job_data
);
   localparam int SW = PCW + 3;

   logic [CW-1:0]              count_ff, count_in;
   logic                       in_pulse_ff, in_pulse_in;
   logic [PCW-1:0]             pcount_ff, pcount_in;
   logic signed [SAMPLE_W-1:0] ppv_ff, ppv_in;
   logic [TIME_W-1:0]          ppt_ff, ppt_in;
   logic [TIME_W-1:0]          selt_ff, selt_in;
   logic                       selv_ff, selv_in;
   logic signed [SAMPLE_W-1:0] minv_ff, minv_in;
   logic [AW-1:0]              mini_ff, mini_in;
   logic                       store;

   always_comb begin
      count_in    = count_ff;
      in_pulse_in = in_pulse_ff;
      pcount_in   = pcount_ff;
      ppv_in      = ppv_ff;
      ppt_in      = ppt_ff;
      selt_in     = selt_ff;
      selv_in     = selv_ff;
      minv_in     = minv_ff;
      mini_in     = mini_ff;
      store       = take && (count_ff < CW'(RECORD_DEPTH));
      if (store) begin
         if (count_ff == '0 || pmt_sample < minv_ff) begin
            minv_in = pmt_sample;
            mini_in = count_ff[AW-1:0];
         end
         if (laser_sample > laser_thr) begin
            if (!in_pulse_ff || laser_sample > ppv_ff) begin
               ppv_in = laser_sample;
               ppt_in = sample_time;
            end
            in_pulse_in = 1'b1;
         end else if (in_pulse_ff) begin
            // pulse ends here
            if (pcount_ff < PCW'(MAX_PULSES)) begin
               if (SW'(pcount_ff) == SW'(pulse_sel)) begin
                  selt_in = ppt_ff;
                  selv_in = 1'b1;
               end
               pcount_in = pcount_ff + 1'b1;
            end
            in_pulse_in = 1'b0;
         end
         count_in = count_ff + 1'b1;
      end
      if (take && last_sample && in_pulse_in) begin
         // pulse still open at record end
         if (pcount_in < PCW'(MAX_PULSES)) begin
            if (SW'(pcount_in) == SW'(pulse_sel)) begin
               selt_in = ppt_in;
               selv_in = 1'b1;
            end
            pcount_in = pcount_in + 1'b1;
         end
         in_pulse_in = 1'b0;
      end
   end

   assign wr_en    = store;
   assign wr_addr  = count_ff[AW-1:0];
   assign job_push = take && last_sample;
   assign job_data = {count_in, mini_in, minv_in, pcount_in, selv_in, selt_in};

   always_ff @(posedge clock) begin
      if (reset || job_push) begin
         count_ff    <= '0;
         in_pulse_ff <= 1'b0;
         pcount_ff   <= '0;
         ppv_ff      <= '0;
         ppt_ff      <= '0;
         selt_ff     <= '0;
         selv_ff     <= 1'b0;
         minv_ff     <= '0;
         mini_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         in_pulse_ff <= in_pulse_in;
         pcount_ff   <= pcount_in;
         ppv_ff      <= ppv_in;
         ppt_ff      <= ppt_in;
         selt_ff     <= selt_in;
         selv_ff     <= selv_in;
         minv_ff     <= minv_in;
         mini_ff     <= mini_in;
      end
   end
endmodule

// ===== src/wptc_back.sv =====
// Back end: span walk around the pmt minimum and charge integration.
// Depends on wptc_pkg; reads both sample stores through registered ports.
module wptc_back
   import wptc_pkg::*;
#(
   parameter int RECORD_DEPTH = 8192,
   parameter int MAX_PULSES   = 5,
   localparam int AW  = $clog2(RECORD_DEPTH),
   localparam int CW  = $clog2(RECORD_DEPTH + 1),
   localparam int PCW = $clog2(MAX_PULSES + 1),
   localparam int JW  = CW + AW + SAMPLE_W + PCW + 1 + TIME_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  logic [JW-1:0]              job_data,
   output logic                       job_pop,
   input  logic signed [SAMPLE_W-1:0] pmt_thr,
   output logic [AW-1:0]              rd_addr,
   input  logic signed [SAMPLE_W-1:0] pmt_rd,
   input  logic [TIME_W-1:0]          time_rd,
   output logic                       busy,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output result_type                 rsp
);
   localparam int PW   = SAMPLE_W + TIME_W + 1;
   localparam int ACCW = PW + AW + 1;
   localparam logic signed [ACCW-1:0] QMAX =
      {{(ACCW - CHARGE_W + 1){1'b0}}, {(CHARGE_W - 1){1'b1}}};
   localparam logic signed [ACCW-1:0] QMIN = ~QMAX;

   back_state_type             state_ff, state_in;
   logic [CW-1:0]              n_ff, n_in;
   logic [AW-1:0]              peak_ff, peak_in;
   logic signed [SAMPLE_W-1:0] minv_ff, minv_in;
   logic [PCW-1:0]             pcount_ff, pcount_in;
   logic                       selv_ff, selv_in;
   logic [TIME_W-1:0]          selt_ff, selt_in;
   logic [AW-1:0]              start_ff, start_in;
   logic [AW-1:0]              end_ff, end_in;
   logic [AW-1:0]              k_ff, k_in;
   logic [1:0]                 status_ff, status_in;
   logic signed [SAMPLE_W-1:0] prevp_ff, prevp_in;
   logic [TIME_W-1:0]          prevt_ff, prevt_in;
   logic signed [PW-1:0]       prod_ff, prod_in;
   logic                       prodv_ff, prodv_in;
   logic signed [ACCW-1:0]     acc_ff, acc_in;
   logic                       rspv_ff, rspv_in;
   result_type                 rsp_ff, rsp_in;
   logic [TIME_W-1:0]          dt;
   logic signed [ACCW-1:0]     q;

   always_comb begin
      state_in  = state_ff;
      {n_in, peak_in, minv_in, pcount_in, selv_in, selt_in} =
         {n_ff, peak_ff, minv_ff, pcount_ff, selv_ff, selt_ff};
      start_in  = start_ff;
      end_in    = end_ff;
      k_in      = k_ff;
      status_in = status_ff;
      prevp_in  = prevp_ff;
      prevt_in  = prevt_ff;
      dt        = time_rd - prevt_ff;
      prod_in   = PW'(prevp_ff) * PW'($signed({1'b0, dt}));
      prodv_in  = 1'b0;
      acc_in    = prodv_ff ? acc_ff + ACCW'(prod_ff) : acc_ff;
      rspv_in   = rspv_ff && !rsp_ready;
      rsp_in    = rsp_ff;
      job_pop   = 1'b0;
      rd_addr   = start_ff;
      q         = acc_ff;
      if (acc_ff > QMAX) q = QMAX;
      if (acc_ff < QMIN) q = QMIN;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               {n_in, peak_in, minv_in, pcount_in, selv_in, selt_in} = job_data;
               start_in  = job_data[JW-CW-1 -: AW];
               end_in    = job_data[JW-CW-1 -: AW];
               status_in = STATUS_OK;
               acc_in    = '0;
               state_in  = BK_LEFT_RD;
            end
         end
         BK_LEFT_RD: begin
            rd_addr  = start_ff;
            state_in = BK_LEFT_CHK;
         end
         BK_LEFT_CHK: begin
            state_in = BK_RIGHT_RD;
            if (pmt_rd < pmt_thr) begin
               if (start_ff == '0) begin
                  status_in = STATUS_START;
               end else begin
                  start_in = start_ff - 1'b1;
                  if (start_ff == AW'(1)) begin
                     status_in = STATUS_START;
                  end else begin
                     state_in = BK_LEFT_RD;
                  end
               end
            end
         end
         BK_RIGHT_RD: begin
            rd_addr  = end_ff;
            state_in = BK_RIGHT_CHK;
         end
         BK_RIGHT_CHK: begin
            k_in     = start_ff;
            state_in = BK_INT_RD;
            if (pmt_rd < pmt_thr) begin
               if (CW'(end_ff) + 1'b1 >= n_ff) begin
                  if (status_ff == STATUS_OK) status_in = STATUS_END;
               end else begin
                  end_in   = end_ff + 1'b1;
                  state_in = BK_RIGHT_RD;
               end
            end
         end
         BK_INT_RD: begin
            rd_addr  = k_ff;
            state_in = BK_INT_CHK;
         end
         BK_INT_CHK: begin
            prodv_in = (k_ff != start_ff);
            prevp_in = pmt_rd;
            prevt_in = time_rd;
            if (k_ff == end_ff) begin
               state_in = BK_FLUSH;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = BK_INT_RD;
            end
         end
         BK_FLUSH: begin
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (!rspv_ff || rsp_ready) begin
               rspv_in                   = 1'b1;
               rsp_in.laser_peak_time    = selv_ff ? selt_ff : '0;
               rsp_in.laser_pulse_count  = CNT_OUT_W'(pcount_ff);
               rsp_in.laser_missing      = !selv_ff;
               rsp_in.pmt_peak_index     = IDX_W'(peak_ff);
               rsp_in.pmt_peak_value     = minv_ff;
               rsp_in.pmt_start_index    = IDX_W'(start_ff);
               rsp_in.pmt_end_index      = IDX_W'(end_ff);
               rsp_in.charge             = q[CHARGE_W-1:0];
               rsp_in.pmt_status         = status_ff;
               state_in                  = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rspv_ff  <= 1'b0;
         prodv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
         prodv_ff <= prodv_in;
      end
   end

   always_ff @(posedge clock) begin
      {n_ff, peak_ff, minv_ff, pcount_ff, selv_ff, selt_ff} <=
         {n_in, peak_in, minv_in, pcount_in, selv_in, selt_in};
      start_ff  <= start_in;
      end_ff    <= end_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      prevp_ff  <= prevp_in;
      prevt_ff  <= prevt_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != BK_IDLE) && (state_ff != BK_OUT);
   assign rsp_valid = rspv_ff;
   assign rsp       = rsp_ff;
endmodule

// ===== src/waveform_pulse_timing_and_charge.sv =====
// Top level of the pulse timing and charge block.
// Depends on wptc_pkg, wptc_ram, wptc_queue, wptc_front, wptc_back and the macros header.
//
//  Channel | Prefix | Moves per transfer
//  --------+--------+-------------------------------------------------------
//  input   | req_   | one sample: timestamp, pmt code, laser code, last flag
//  result  | rsp_   | one record summary: laser timing, pmt span and charge
//  config  | csr_   | one register write: index and 16-bit data
//
// Samples load one per cycle. After the last sample the back end takes the job
// when idle, checks samples on the left and right walks (stop sample included),
// integrates start to end inclusive, then flushes and loads the output register,
// reading the stores through their registered ports. Input stalls while a job
// waits or the back end is busy; a held result stalls the next result and,
// once a job waits, the input. Reset is synchronous; no clearing pass.
`include "waveform_pulse_timing_and_charge_macros.svh"
module waveform_pulse_timing_and_charge
   import wptc_pkg::*;
#(
   parameter int RECORD_DEPTH = 8192,
   parameter int MAX_PULSES   = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [TIME_W-1:0]          req_sample_time,
   input  logic signed [SAMPLE_W-1:0] req_pmt_sample,
   input  logic signed [SAMPLE_W-1:0] req_laser_sample,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [TIME_W-1:0]          rsp_laser_peak_time,
   output logic [CNT_OUT_W-1:0]       rsp_laser_pulse_count,
   output logic                       rsp_laser_missing,
   output logic [IDX_W-1:0]           rsp_pmt_peak_index,
   output logic signed [SAMPLE_W-1:0] rsp_pmt_peak_value,
   output logic [IDX_W-1:0]           rsp_pmt_start_index,
   output logic [IDX_W-1:0]           rsp_pmt_end_index,
   output logic signed [CHARGE_W-1:0] rsp_charge,
   output logic [1:0]                 rsp_pmt_status,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [SAMPLE_W-1:0]        csr_data
);
   localparam int AW  = $clog2(RECORD_DEPTH);
   localparam int CW  = $clog2(RECORD_DEPTH + 1);
   localparam int PCW = $clog2(MAX_PULSES + 1);
   localparam int JW  = CW + AW + SAMPLE_W + PCW + 1 + TIME_W;

   // configuration registers
   logic signed [SAMPLE_W-1:0] laser_thr_ff;
   logic signed [SAMPLE_W-1:0] pmt_thr_ff;
   logic [2:0]                 pulse_sel_ff;

   logic              take;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic              job_push, job_pop, job_valid;
   logic [JW-1:0]     job_in, job_out;
   logic              back_busy;
   logic signed [SAMPLE_W-1:0] pmt_rd;
   logic [TIME_W-1:0] time_rd;
   result_type        rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         laser_thr_ff <= LASER_THR_RST;
         pmt_thr_ff   <= PMT_THR_RST;
         pulse_sel_ff <= PULSE_SEL_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LASER_THR: laser_thr_ff <= csr_data;
            CSR_PMT_THR:   pmt_thr_ff   <= csr_data;
            CSR_PULSE_SEL: pulse_sel_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // stores belong to the front end unless the back end is walking them
   assign req_ready = !job_valid && !back_busy;
   assign take      = req_valid && req_ready;

   wptc_front #(.RECORD_DEPTH(RECORD_DEPTH), .MAX_PULSES(MAX_PULSES)) u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .sample_time  (req_sample_time),
      .pmt_sample   (req_pmt_sample),
      .laser_sample (req_laser_sample),
      .last_sample  (req_last_sample),
      .laser_thr    (laser_thr_ff),
      .pulse_sel    (pulse_sel_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .job_push     (job_push),
      .job_data     (job_in)
   );

   wptc_ram #(.WIDTH(SAMPLE_W), .DEPTH(RECORD_DEPTH)) u_pmt_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pmt_sample),
      .rd_addr (rd_addr),
      .rd_data (pmt_rd)
   );

   wptc_ram #(.WIDTH(TIME_W), .DEPTH(RECORD_DEPTH)) u_time_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample_time),
      .rd_addr (rd_addr),
      .rd_data (time_rd)
   );

   wptc_queue #(.WIDTH(JW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_data  (job_out),
      .not_empty (job_valid)
   );

   wptc_back #(.RECORD_DEPTH(RECORD_DEPTH), .MAX_PULSES(MAX_PULSES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_out),
      .job_pop   (job_pop),
      .pmt_thr   (pmt_thr_ff),
      .rd_addr   (rd_addr),
      .pmt_rd    (pmt_rd),
      .time_rd   (time_rd),
      .busy      (back_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_laser_peak_time   = rsp.laser_peak_time;
   assign rsp_laser_pulse_count = rsp.laser_pulse_count;
   assign rsp_laser_missing     = rsp.laser_missing;
   assign rsp_pmt_peak_index    = rsp.pmt_peak_index;
   assign rsp_pmt_peak_value    = rsp.pmt_peak_value;
   assign rsp_pmt_start_index   = rsp.pmt_start_index;
   assign rsp_pmt_end_index     = rsp.pmt_end_index;
   assign rsp_charge            = rsp.charge;
   assign rsp_pmt_status        = rsp.pmt_status;

   // no sample write while the walk owns the stores
   `WPTC_ASSERT_IMP(a_no_write_in_walk, clock, reset, back_busy, !wr_en)
   // a popped job starts a walk
   `WPTC_ASSERT_NXT(a_pop_starts_walk, clock, reset, job_pop, back_busy)
   // only the three defined status codes are produced
   `WPTC_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_pmt_status <= STATUS_END)
   // a missing pulse reports time zero
   `WPTC_ASSERT_IMP(a_missing_time, clock, reset, rsp_valid && rsp_laser_missing,
                    rsp_laser_peak_time == '0)
endmodule

// ===== tb/wptc_record_checker.sv =====
// Record checker for the pulse timing and charge block: watches the sample,
// result and register channels, predicts each record summary and compares.
// Depends on wptc_pkg.
module wptc_record_checker
   import wptc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [TIME_W-1:0]          req_sample_time,
   input  logic signed [SAMPLE_W-1:0] req_pmt_sample,
   input  logic signed [SAMPLE_W-1:0] req_laser_sample,
   input  logic                       req_last_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [TIME_W-1:0]          rsp_laser_peak_time,
   input  logic [CNT_OUT_W-1:0]       rsp_laser_pulse_count,
   input  logic                       rsp_laser_missing,
   input  logic [IDX_W-1:0]           rsp_pmt_peak_index,
   input  logic signed [SAMPLE_W-1:0] rsp_pmt_peak_value,
   input  logic [IDX_W-1:0]           rsp_pmt_start_index,
   input  logic [IDX_W-1:0]           rsp_pmt_end_index,
   input  logic signed [CHARGE_W-1:0] rsp_charge,
   input  logic [1:0]                 rsp_pmt_status,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [SAMPLE_W-1:0]        csr_data,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 8192;
   localparam int PULSE_MAX  = 5;
   localparam longint Q_MAX  = 64'sd140737488355327;
   localparam longint Q_MIN  = -Q_MAX - 1;

   logic signed [15:0] laser_thr, pmt_thr;
   logic [2:0]         sel;

   logic signed [15:0] pmt_mem [DEPTH];
   logic [31:0]        time_mem [DEPTH];
   int                 n_stored;
   bit                 open_pulse, sel_found;
   int                 n_pulses;
   logic signed [15:0] open_peak;
   logic [31:0]        open_peak_t, sel_t;
   logic signed [15:0] pmt_min;
   int                 pmt_min_at;

   result_type summaries [$];

   function automatic void clear_record();
      n_stored = 0; open_pulse = 0; n_pulses = 0; open_peak = 0;
      open_peak_t = 0; sel_t = 0; sel_found = 0; pmt_min = 0; pmt_min_at = 0;
   endfunction

   function automatic void end_pulse();
      if (n_pulses < PULSE_MAX) begin
         if (n_pulses == int'(sel)) begin
            sel_t = open_peak_t;
            sel_found = 1;
         end
         n_pulses++;
      end
      open_pulse = 0;
   endfunction

   // Walk out from the pmt minimum and integrate over the span.
   function automatic result_type summarize();
      result_type r;
      int lo, hi, k;
      logic [1:0] st;
      longint q;
      lo = pmt_min_at; hi = pmt_min_at; st = STATUS_OK; q = 0;
      while (pmt_mem[lo] < pmt_thr) begin
         if (lo == 0) begin st = STATUS_START; break; end
         lo--;
         if (lo == 0) begin st = STATUS_START; break; end
      end
      while (pmt_mem[hi] < pmt_thr) begin
         if (hi + 1 >= n_stored) begin
            if (st == STATUS_OK) st = STATUS_END;
            break;
         end
         hi++;
      end
      for (k = lo; k < hi; k++)
         q += longint'(pmt_mem[k]) * longint'({32'd0, time_mem[k+1] - time_mem[k]});
      if (q > Q_MAX) q = Q_MAX;
      if (q < Q_MIN) q = Q_MIN;
      r.laser_peak_time   = sel_found ? sel_t : 32'd0;
      r.laser_pulse_count = n_pulses[2:0];
      r.laser_missing     = !sel_found;
      r.pmt_peak_index    = pmt_min_at[12:0];
      r.pmt_peak_value    = pmt_min;
      r.pmt_start_index   = lo[12:0];
      r.pmt_end_index     = hi[12:0];
      r.charge            = q[47:0];
      r.pmt_status        = st;
      return r;
   endfunction

   function automatic void take_sample();
      int i;
      if (n_stored < DEPTH) begin
         i = n_stored;
         pmt_mem[i]  = req_pmt_sample;
         time_mem[i] = req_sample_time;
         if (i == 0 || req_pmt_sample < pmt_min) begin
            pmt_min = req_pmt_sample;
            pmt_min_at = i;
         end
         if (req_laser_sample > laser_thr) begin
            if (!open_pulse || req_laser_sample > open_peak) begin
               open_peak = req_laser_sample;
               open_peak_t = req_sample_time;
            end
            open_pulse = 1;
         end else if (open_pulse) begin
            end_pulse();
         end
         n_stored = i + 1;
      end
      if (req_last_sample) begin
         if (open_pulse) end_pulse();
         summaries.push_back(summarize());
         clear_record();
      end
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         laser_thr = LASER_THR_RST;
         pmt_thr = PMT_THR_RST;
         sel = PULSE_SEL_RST;
         clear_record();
         summaries.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LASER_THR: laser_thr = csr_data;
               CSR_PMT_THR:   pmt_thr = csr_data;
               CSR_PULSE_SEL: sel = csr_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) take_sample();
         if (rsp_valid && rsp_ready) begin
            if (summaries.size() == 0) begin
               $display("%0t: unexpected result transfer", $time);
               fail_count++;
            end else begin
               want = summaries.pop_front();
               check_field("laser_peak_time", want.laser_peak_time, rsp_laser_peak_time);
               check_field("laser_pulse_count", want.laser_pulse_count,
                           rsp_laser_pulse_count);
               check_field("laser_missing", want.laser_missing, rsp_laser_missing);
               check_field("pmt_peak_index", want.pmt_peak_index, rsp_pmt_peak_index);
               check_field("pmt_peak_value", 16'(want.pmt_peak_value),
                           16'(rsp_pmt_peak_value));
               check_field("pmt_start_index", want.pmt_start_index, rsp_pmt_start_index);
               check_field("pmt_end_index", want.pmt_end_index, rsp_pmt_end_index);
               check_field("charge", 48'(want.charge), 48'(rsp_charge));
               check_field("pmt_status", want.pmt_status, rsp_pmt_status);
            end
         end
      end
      pending = summaries.size();
   end
endmodule

// ===== tb/waveform_pulse_timing_and_charge_tb.sv =====
// Top of the pulse timing and charge testbench: clock, reset, record stimulus
// and register phases; checking lives in wptc_record_checker.
// Depends on wptc_pkg, wptc_record_checker and the block's RTL.
module waveform_pulse_timing_and_charge_tb
   import wptc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       req_valid = 0;
   logic                       req_ready;
   logic [TIME_W-1:0]          req_sample_time = 0;
   logic signed [SAMPLE_W-1:0] req_pmt_sample = 0;
   logic signed [SAMPLE_W-1:0] req_laser_sample = 0;
   logic                       req_last_sample = 0;
   logic                       rsp_valid;
   logic                       rsp_ready = 0;
   logic [TIME_W-1:0]          rsp_laser_peak_time;
   logic [CNT_OUT_W-1:0]       rsp_laser_pulse_count;
   logic                       rsp_laser_missing;
   logic [IDX_W-1:0]           rsp_pmt_peak_index;
   logic signed [SAMPLE_W-1:0] rsp_pmt_peak_value;
   logic [IDX_W-1:0]           rsp_pmt_start_index;
   logic [IDX_W-1:0]           rsp_pmt_end_index;
   logic signed [CHARGE_W-1:0] rsp_charge;
   logic [1:0]                 rsp_pmt_status;
   logic                       csr_valid = 0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_LASER_THR;
   logic [SAMPLE_W-1:0]        csr_data = 0;

   int fail_count, pending;

   // calm = no idling on either side for a stretch of records
   bit calm = 0;
   // thresholds currently programmed, so shaped records straddle them
   int laser_thr_now = 4000;
   int pmt_thr_now = -60;

   always #5 clock = ~clock;

   waveform_pulse_timing_and_charge uut (.*);

   wptc_record_checker chk (.*);

   // Result side is not ready with about 38% odds unless calm.
   always @(negedge clock)
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);

   function automatic logic signed [15:0] clamp16(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Sender gap: each cycle idles with about 38% odds.
   task automatic sender_gap();
      if (!calm)
         while ($urandom_range(99) < 38) @(negedge clock);
   endtask

   // One sample transfer; starts and ends at a falling edge.
   task automatic send_sample(logic [31:0] t, int pmt, int las, bit last);
      sender_gap();
      req_valid = 1;
      req_sample_time = t;
      req_pmt_sample = clamp16(pmt);
      req_laser_sample = clamp16(las);
      req_last_sample = last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 0;
   endtask

   // Wait until every summary is back, then a short settle for the back end.
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic reg_write(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      sender_gap();
      csr_valid = 1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
      case (idx)
         CSR_LASER_THR: laser_thr_now = int'($signed(val));
         CSR_PMT_THR:   pmt_thr_now = int'($signed(val));
         default: ;
      endcase
   endtask

   // One record of n samples. Shaped records put a pmt dip below threshold
   // and laser bursts above threshold; unshaped ones use raw random codes.
   task automatic send_record(int n, bit shaped);
      logic [31:0] t;
      int dip_at, dip_w, i, pmt, las;
      bit burst;
      t = $urandom;
      dip_at = $urandom_range(n - 1, 0);
      dip_w = $urandom_range(n / 3 + 1, 0);
      burst = $urandom_range(1);
      for (i = 0; i < n; i++) begin
         if (shaped) begin
            t += $urandom_range(40, 1);
            if (i >= dip_at && i <= dip_at + dip_w)
               pmt = pmt_thr_now - 1 - $urandom_range(20000);
            else
               pmt = pmt_thr_now + $urandom_range(300) - 20;
            if ($urandom_range(3) == 0) burst = !burst;
            las = burst ? laser_thr_now + 1 + $urandom_range(3000)
                        : laser_thr_now - $urandom_range(3000);
         end else begin
            t += $urandom;
            pmt = int'($signed(16'($urandom)));
            las = int'($signed(16'($urandom)));
         end
         send_sample(t, pmt, las, i == n - 1);
      end
   endtask

   initial begin
      int ph, r;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: single sample at the field extremes.
      send_sample(32'hffff_ffff, -32768, 32767, 1);
      send_sample(32'h0000_0000, 32767, -32768, 1);
      // Peak at index 0 below threshold: span reaches start.
      send_sample(100, -5000, 0, 0);
      send_sample(110, -10, 0, 0);
      send_sample(120, 0, 0, 1);
      // Span reaches the end, laser pulse still open at record end.
      send_sample(10, 0, 0, 0);
      send_sample(20, -100, 5000, 0);
      send_sample(30, -900, 6000, 0);
      send_sample(40, -300, 6000, 1);
      // Peak not below threshold: empty span; timestamps wrap.
      send_sample(32'hffff_fff0, 100, 0, 0);
      send_sample(32'h0000_0010, 50, 0, 1);
      // Seven pulses, more than the five kept; pulse 1 selected.
      for (r = 0; r < 14; r++)
         send_sample(200 + r, -70 - r, (r % 2 == 0) ? 4001 + r : 4000, r == 13);
      drain();

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               reg_write(CSR_LASER_THR, 16'h7fff);
               reg_write(CSR_PMT_THR, 16'h7fff);
               reg_write(CSR_PULSE_SEL, 16'd0);
            end
            1: begin
               reg_write(CSR_LASER_THR, 16'h8000);
               reg_write(CSR_PMT_THR, 16'h8000);
               reg_write(CSR_PULSE_SEL, 16'd4);
            end
            2: begin
               reg_write(CSR_LASER_THR, 16'd4000);
               reg_write(CSR_PMT_THR, -16'sd60);
               reg_write(CSR_PULSE_SEL, 16'd7);
            end
            default: begin
               reg_write(CSR_LASER_THR, 16'($urandom));
               reg_write(CSR_PMT_THR, 16'($urandom_range(2000)) - 16'd1000);
               reg_write(CSR_PULSE_SEL, 16'($urandom_range(5)));
            end
         endcase
         calm = (ph == 4);
         for (r = 0; r < 4; r++)
            send_record($urandom_range(32, 1), $urandom_range(3) != 0);
         // sender holds off until every summary of the phase is back
         drain();
      end
      calm = 0;

      drain();
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #30ms;
      $display("status: fail");
      $finish;
   end
endmodule
